/* hdl/dllc_pkg.sv */
// Package for the linked list cursor block: request and result types, codes.
// No dependencies.
package dllc_pkg;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0, FN_FIRST = 3'd1, FN_FWD = 3'd2,
    FN_BACK = 3'd3, FN_REMOVE = 3'd4, FN_COUNT = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_END = 2'd1, ST_FULL = 2'd2, ST_UNSET = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_READ, PH_FIX
  } phase_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [4:0]  item_total;
  } res_t;
endpackage

/* hdl/dllc_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dllc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/doubly_linked_list_cursor.sv */
// Linked list with cursor over a node pool held in RAMs (value, fwd, back).
// The result strobe is registered from the read phase; a forward or
// backward step that lands on a node strobes from fix-up instead
// (second read for its value). One request at a time: read, fix-up with
// deferred back-link write, then idle for next accept. Results cannot stall.
// Reset: list empty, every node free, cursor unset; RAMs are not cleared.
// Depends on dllc_pkg and dllc_ram.
module doubly_linked_list_cursor import dllc_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_strobe,
  output res_t out_res
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  phase_t ph_r, ph_nxt;
  logic [2:0] fn_r;
  logic [VALUE_WIDTH-1:0] vin_r;
  logic [DEPTH-1:0] free_r, free_nxt;
  logic [PW-1:0] head_r, head_nxt, cur_r, cur_nxt, cnt_r, cnt_nxt;
  logic [PW-1:0] node_r;
  logic strobe_r, strobe_nxt;
  res_t res_r, res_nxt;

  logic [AW-1:0] raddr;
  logic [VALUE_WIDTH-1:0] rval;
  logic [PW-1:0] rfwd, rbck;
  logic v_we, f_we, b_we;
  logic [AW-1:0] v_wa, f_wa, b_wa;
  logic [VALUE_WIDTH-1:0] v_wd;
  logic [PW-1:0] f_wd, b_wd;
  logic [PW-1:0] fix_ptr_r, fix_ptr_nxt, fix_val_r, fix_val_nxt;
  logic fix_en_r, fix_en_nxt;
  logic [PW-1:0] low_free;
  logic [PW-1:0] node_nxt;

  dllc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr, .rdata(rval));
  dllc_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_fwd (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr, .rdata(rfwd));
  dllc_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_bck (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr, .rdata(rbck));

  always_comb begin
    low_free = NIL;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_r[i]) low_free = PW'(i);
    end
  end

  assign busy = (ph_r != PH_IDLE);
  assign out_strobe = strobe_r;
  assign out_res = res_r;

  always_comb begin
    ph_nxt = ph_r;
    free_nxt = free_r;
    head_nxt = head_r;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    node_nxt = node_r;
    strobe_nxt = 1'b0;
    res_nxt = res_r;
    fix_ptr_nxt = fix_ptr_r;
    fix_val_nxt = fix_val_r;
    fix_en_nxt = 1'b0;
    raddr = node_r[AW-1:0];
    v_we = 1'b0; f_we = 1'b0; b_we = 1'b0;
    v_wa = '0; f_wa = '0; b_wa = '0;
    v_wd = vin_r; f_wd = '0; b_wd = '0;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          ph_nxt = PH_READ;
          unique case (in_req.func)
            FN_FIRST: node_nxt = head_r;
            default:  node_nxt = cur_r;
          endcase
          raddr = (in_req.func == FN_FIRST) ? head_r[AW-1:0] : cur_r[AW-1:0];
        end
      end
      PH_READ: begin
        ph_nxt = PH_FIX;
        strobe_nxt = 1'b1;
        res_nxt.value_out = '0;
        res_nxt.status = ST_OK;
        priority case (fn_r)
          FN_INSERT: begin
            if (low_free == NIL) begin
              res_nxt.status = ST_FULL;
            end else begin
              free_nxt[low_free[AW-1:0]] = 1'b0;
              v_we = 1'b1; v_wa = low_free[AW-1:0];
              f_we = 1'b1; f_wa = low_free[AW-1:0]; f_wd = head_r;
              b_we = 1'b1; b_wa = low_free[AW-1:0]; b_wd = NIL;
              fix_en_nxt = (head_r != NIL);
              fix_ptr_nxt = head_r; fix_val_nxt = low_free;
              head_nxt = low_free;
              cnt_nxt = cnt_r + PW'(1);
            end
          end
          FN_FIRST: begin
            if (head_r == NIL) begin
              res_nxt.status = ST_END;
            end else begin
              cur_nxt = head_r;
              res_nxt.value_out = 32'(rval);
            end
          end
          FN_FWD, FN_BACK: begin
            if (cur_r == NIL) begin
              res_nxt.status = ST_UNSET;
            end else begin
              node_nxt = (fn_r == FN_FWD) ? rfwd : rbck;
              if (node_nxt == NIL) begin
                res_nxt.status = ST_END;
              end else begin
                cur_nxt = node_nxt;
                raddr = node_nxt[AW-1:0];
                ph_nxt = PH_FIX;
                strobe_nxt = 1'b0;
              end
            end
          end
          FN_REMOVE: begin
            if (cur_r == NIL) begin
              res_nxt.status = ST_UNSET;
            end else begin
              res_nxt.value_out = 32'(rval);
              if (rbck != NIL) begin
                f_we = 1'b1; f_wa = rbck[AW-1:0]; f_wd = rfwd;
                cur_nxt = rbck;
              end else begin
                head_nxt = rfwd;
                cur_nxt = rfwd;
              end
              fix_en_nxt = (rfwd != NIL);
              fix_ptr_nxt = rfwd; fix_val_nxt = rbck;
              free_nxt[cur_r[AW-1:0]] = 1'b1;
              if (cnt_r != '0) cnt_nxt = cnt_r - PW'(1);
            end
          end
          default: ;
        endcase
        res_nxt.item_total = 5'(cnt_nxt);
      end
      PH_FIX: begin
        ph_nxt = PH_IDLE;
        if (fix_en_r) begin
          b_we = 1'b1; b_wa = fix_ptr_r[AW-1:0]; b_wd = fix_val_r;
        end
        if ((fn_r == FN_FWD || fn_r == FN_BACK) && !strobe_r) begin
          strobe_nxt = 1'b1;
          res_nxt.status = ST_OK;
          res_nxt.value_out = 32'(rval);
          res_nxt.item_total = 5'(cnt_r);
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      free_r <= '1;
      head_r <= NIL;
      cur_r <= NIL;
      cnt_r <= '0;
      strobe_r <= 1'b0;
      fix_en_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      free_r <= free_nxt;
      head_r <= head_nxt;
      cur_r <= cur_nxt;
      cnt_r <= cnt_nxt;
      strobe_r <= strobe_nxt;
      fix_en_r <= fix_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == PH_IDLE && start) begin
      fn_r <= in_req.func;
      vin_r <= VALUE_WIDTH'(in_req.value_in);
    end
    node_r <= node_nxt;
    res_r <= res_nxt;
    fix_ptr_r <= fix_ptr_nxt;
    fix_val_r <= fix_val_nxt;
  end

  a_cnt_free: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) + 32'($countones(free_r)) == 32'(DEPTH))
    else $error("count and free map disagree");
  a_head_nil: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == NIL))
    else $error("empty list with head set");
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_IDLE && start) |=> ##2 (out_strobe || $past(out_strobe)))
    else $error("request without result");
  a_no_start_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("double result");
endmodule
